/* src/cpma_pkg.sv */
`timescale 1ns / 1ps

package cpma_pkg;

  // window and field geometry
  localparam int unsigned WINDOW_LEN       = 20;
  localparam int unsigned SMP_W            = 10;
  localparam int unsigned PCT_W            = 15;
  localparam int unsigned PERCENT_ONE      = 25600;
  localparam int unsigned FULL_SCALE_RESET = 700;

  // shared divider geometry
  localparam int unsigned NUM_W  = 25;
  localparam int unsigned DIV_W  = 10;
  localparam int unsigned SUM_W  = $clog2(WINDOW_LEN * PERCENT_ONE + 1);
  localparam int unsigned SLOT_W = $clog2(WINDOW_LEN);
  localparam int unsigned CNT_W  = $clog2(NUM_W + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE_GO,
    ST_SCALE_RUN,
    ST_UPDATE,
    ST_MEAN_GO,
    ST_MEAN_RUN
  } cpma_state_e;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] steps;
  } div_ctrl_t;

endpackage

/* src/cpma_ifs.sv */
`timescale 1ns / 1ps

interface cpma_sample_if;
  import cpma_pkg::*;
  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface cpma_result_if;
  import cpma_pkg::*;
  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] average_percent;
  logic [PCT_W-1:0] instant_percent;
  modport source (output valid, output average_percent, output instant_percent, input ready);
  modport sink   (input valid, input average_percent, input instant_percent, output ready);
endinterface

/* src/cpma_divider.sv */
`timescale 1ns / 1ps

module cpma_divider import cpma_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_ctrl_t        ctrl_i,
  input  logic [NUM_W-1:0] numer_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);

  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [DIV_W-1:0] rem_q;
  logic [DIV_W-1:0] dvs_q;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic             ge;
  logic [DIV_W-1:0] rem_d;

  // one restoring step: bring down the next numerator bit
  always_comb begin
    shifted = {rem_q, num_q[NUM_W-1]};
    ge      = shifted >= {1'b0, dvs_q};
    diff    = shifted - {1'b0, dvs_q};
    rem_d   = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.start) begin
      cnt_q <= ctrl_i.steps;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // numerator shifts out at the top, quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      num_q <= numer_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = num_q;

endmodule

/* src/clamped_percent_moving_average.sv */
`timescale 1ns / 1ps

// channel    | dir | handshake     | payload
// -----------+-----+---------------+------------------------------------------
// sample_i   | in  | valid / ready | sample[9:0]
// result_o   | out | valid / ready | average_percent[14:0], instant_percent[14:0]
// cfg        | in  | cfg_we_i      | cfg_data_i[9:0] = full_scale
//
// A sample transaction gives a valid result after a scaling pass, then a mean pass,
// both run on the shared one-bit-per-cycle divider; the mean covers a 20-entry window.
// The next sample is taken only once the block is back in idle, one sample at a time.
// Reset clears control state; the window reads as zeros through per-entry valid bits.
// A stalled result waits in the output register while the next sample is worked on;
// that sample then holds at the end of its mean pass until the output register frees.

module clamped_percent_moving_average import cpma_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SMP_W-1:0]  cfg_data_i,
  cpma_sample_if.sink       sample_i,
  cpma_result_if.source     result_o
);

  cpma_state_e             state_q, state_d;
  logic [SMP_W-1:0]        fs_q;
  logic [SMP_W-1:0]        d_eff;
  logic [SMP_W-1:0]        smp_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [SUM_W-1:0]        sum_q;
  logic [WINDOW_LEN-1:0]   vld_q;
  logic [PCT_W-1:0]        win_mem [WINDOW_LEN];
  logic [PCT_W-1:0]        old_q;
  logic                    old_vld_q;
  logic [PCT_W-1:0]        inst_q;
  logic                    out_vld_q;
  logic [PCT_W-1:0]        avg_q;
  logic [PCT_W-1:0]        out_inst_q;

  logic                    accept;
  logic                    out_free;
  logic                    do_update;
  logic                    load_out;
  div_ctrl_t               div_ctrl;
  logic [NUM_W-1:0]        div_numer;
  logic [DIV_W-1:0]        div_divisor;
  logic                    div_busy;
  logic [NUM_W-1:0]        div_quot;
  logic [PCT_W-1:0]        inst_new;
  logic [PCT_W-1:0]        old_val;

  // full scale of zero acts as one
  assign d_eff    = (fs_q == '0) ? SMP_W'(1) : fs_q;
  assign accept   = sample_i.valid && sample_i.ready;
  assign out_free = !out_vld_q || result_o.ready;
  assign inst_new = div_quot[PCT_W-1:0];
  assign old_val  = old_vld_q ? old_q : '0;

  assign sample_i.ready           = state_q == ST_IDLE;
  assign result_o.valid           = out_vld_q;
  assign result_o.average_percent = avg_q;
  assign result_o.instant_percent = out_inst_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= SMP_W'(FULL_SCALE_RESET);
    end else if (cfg_we_i) begin
      fs_q <= cfg_data_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (accept) state_d = ST_SCALE_GO;
      ST_SCALE_GO:  state_d = ST_SCALE_RUN;
      ST_SCALE_RUN: if (!div_busy) state_d = ST_UPDATE;
      ST_UPDATE:    state_d = ST_MEAN_GO;
      ST_MEAN_GO:   state_d = ST_MEAN_RUN;
      ST_MEAN_RUN:  if (!div_busy && out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    div_ctrl    = '0;
    div_numer   = NUM_W'(smp_q) * NUM_W'(PERCENT_ONE);
    div_divisor = d_eff;
    do_update   = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      ST_SCALE_GO: begin
        div_ctrl.start = 1'b1;
        div_ctrl.steps = CNT_W'(NUM_W);
      end
      ST_UPDATE: begin
        do_update = 1'b1;
      end
      ST_MEAN_GO: begin
        div_ctrl.start = 1'b1;
        div_ctrl.steps = CNT_W'(SUM_W);
        div_numer      = {sum_q, {(NUM_W - SUM_W){1'b0}}};
        div_divisor    = DIV_W'(WINDOW_LEN);
      end
      ST_MEAN_RUN: begin
        load_out = !div_busy && out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // clamp on the way in
  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q <= (sample_i.sample > d_eff) ? d_eff : sample_i.sample;
    end
  end

  cpma_divider u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (div_ctrl),
    .numer_i   (div_numer),
    .divisor_i (div_divisor),
    .busy_o    (div_busy),
    .quot_o    (div_quot)
  );

  // window control: running sum, oldest slot, entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      slot_q <= '0;
      vld_q  <= '0;
    end else if (do_update) begin
      sum_q          <= sum_q - SUM_W'(old_val) + SUM_W'(inst_new);
      vld_q[slot_q]  <= 1'b1;
      slot_q         <= (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + SLOT_W'(1);
    end
  end

  // window memory, registered read of the oldest entry
  always_ff @(posedge clk_i) begin
    if (do_update) begin
      win_mem[slot_q] <= inst_new;
      inst_q          <= inst_new;
    end
    old_q     <= win_mem[slot_q];
    old_vld_q <= vld_q[slot_q];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      avg_q      <= div_quot[PCT_W-1:0];
      out_inst_q <= inst_q;
    end
  end

endmodule

/* src/cpma_checker.sv */
`timescale 1ns / 1ps

module cpma_checker import cpma_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [PCT_W-1:0] avg_i,
  input logic [PCT_W-1:0] inst_i
);

  // one sample at a time: ready drops right after a transaction
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while a sample is in work");

  // a new result appears only as the block returns to idle
  a_result_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result loaded while not returning to idle");

  // both percent values stay within one hundred percent
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (avg_i <= PCT_W'(PERCENT_ONE)) && (inst_i <= PCT_W'(PERCENT_ONE)))
    else $error("percent out of range");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(avg_i) && $stable(inst_i))
    else $error("stalled result changed");

endmodule

bind clamped_percent_moving_average cpma_checker u_cpma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .avg_i       (result_o.average_percent),
  .inst_i      (result_o.instant_percent)
);

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import cpma_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_CYCLES  = 120;
  localparam int unsigned IDLE_PCT      = 17;
  localparam int unsigned HOLD_AT       = 300;
  localparam int unsigned HOLD_LEN      = 800;
  localparam int unsigned PHASE_COUNT   = 6;
  localparam int unsigned PHASE_ITEMS   = 205;

  // predictor of the scaled percent window and its queue of expected pairs
  class percent_window_scoreboard;
    typedef struct packed {
      logic [PCT_W-1:0] average_percent;
      logic [PCT_W-1:0] instant_percent;
    } percent_pair_t;

    logic [SMP_W-1:0] full_scale;
    int unsigned      window_entry [WINDOW_LEN];
    int unsigned      window_sum;
    int unsigned      oldest_slot;
    percent_pair_t    pending_pairs[$];
    int unsigned      errors;

    function new();
      full_scale  = SMP_W'(FULL_SCALE_RESET);
      foreach (window_entry[i]) window_entry[i] = 0;
      window_sum  = 0;
      oldest_slot = 0;
      errors      = 0;
    endfunction

    function void set_full_scale(logic [SMP_W-1:0] value);
      full_scale = value;
    endfunction

    function int unsigned pending_count();
      return pending_pairs.size();
    endfunction

    function void report(string what, int unsigned got, int unsigned want);
      if (errors < 100)
        $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $time);
      errors++;
    endfunction

    // one accepted sample: clamp, scale, push into window, take the mean
    function void note_sample(logic [SMP_W-1:0] raw);
      int unsigned   divisor;
      int unsigned   clamped;
      int unsigned   instant;
      percent_pair_t entry;
      divisor = (full_scale == 0) ? 1 : full_scale;
      clamped = (raw > divisor) ? divisor : raw;
      instant = (PERCENT_ONE * clamped) / divisor;
      window_sum = window_sum - window_entry[oldest_slot] + instant;
      window_entry[oldest_slot] = instant;
      oldest_slot = (oldest_slot == WINDOW_LEN - 1) ? 0 : oldest_slot + 1;
      entry.average_percent = PCT_W'(window_sum / WINDOW_LEN);
      entry.instant_percent = PCT_W'(instant);
      pending_pairs.push_back(entry);
    endfunction

    // one accepted result against the oldest expected pair
    function void check_result(logic [PCT_W-1:0] average, logic [PCT_W-1:0] instant);
      percent_pair_t entry;
      if (pending_pairs.size() == 0) begin
        report("unexpected result, average", average, 0);
        return;
      end
      entry = pending_pairs.pop_front();
      if (average !== entry.average_percent)
        report("average_percent", average, entry.average_percent);
      if (instant !== entry.instant_percent)
        report("instant_percent", instant, entry.instant_percent);
    endfunction
  endclass

  logic             clk_i;
  logic             rst_n;
  logic             cfg_we;
  logic [SMP_W-1:0] cfg_data;

  cpma_sample_if smp_if ();
  cpma_result_if res_if ();

  percent_window_scoreboard sb;

  int unsigned cycle_count;
  int unsigned results_seen;
  int unsigned hold_left;
  bit          hold_done;
  bit          calm;

  clamped_percent_moving_average u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .sample_i   (smp_if),
    .result_o   (res_if)
  );

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: check each transaction, random stalls, one long hold-off
  always @(posedge clk_i) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        sb.check_result(res_if.average_percent, res_if.instant_percent);
        results_seen++;
      end
      if (hold_left != 0) begin
        hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      res_if.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // offer one sample, with a random gap before it
  task automatic send_sample(input logic [SMP_W-1:0] value);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= value;
    do @(posedge clk_i); while (!smp_if.ready);
    sb.note_sample(value);
  endtask

  // hold the sample side until every expected result has come back
  task automatic wait_drained();
    smp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_count() != 0) @(posedge clk_i);
  endtask

  // full scale write, only with the block idle
  task automatic write_full_scale(input logic [SMP_W-1:0] value);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    sb.set_full_scale(value);
    @(posedge clk_i);
  endtask

  // random sample: full range or close to full scale
  function automatic logic [SMP_W-1:0] pick_sample(logic [SMP_W-1:0] fs);
    int unsigned lo;
    int unsigned hi;
    if ($urandom_range(1) == 0)
      return SMP_W'($urandom_range(1023, 0));
    lo = (fs > 8) ? fs - 8 : 0;
    hi = (fs < 1015) ? fs + 8 : 1023;
    return SMP_W'($urandom_range(hi, lo));
  endfunction

  initial begin
    logic [SMP_W-1:0] fs;
    sb           = new();
    cycle_count  = 0;
    results_seen = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    calm         = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    smp_if.valid  = 1'b0;
    smp_if.sample = '0;
    res_if.ready  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed: reset full scale, start-up window, clamp edges, bit patterns
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd1);
    send_sample(10'd699);
    send_sample(10'd700);
    send_sample(10'd701);
    send_sample(10'h155);
    send_sample(10'h2aa);
    send_sample(10'd512);

    // smallest full scale
    write_full_scale(10'd1);
    send_sample(10'd0);
    send_sample(10'd1);
    send_sample(10'd1023);

    // largest full scale
    write_full_scale(10'd1023);
    send_sample(10'd1023);
    send_sample(10'd1022);
    send_sample(10'd0);
    send_sample(10'd1);
    send_sample(10'd511);

    // zero full scale acts as one
    write_full_scale(10'd0);
    send_sample(10'd0);
    send_sample(10'd1);
    send_sample(10'd1023);
    send_sample(10'd0);

    // random phases, each with its own full scale
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: fs = SMP_W'(FULL_SCALE_RESET);
        1: fs = 10'd1023;
        2: fs = SMP_W'($urandom_range(1023, 1));
        3: fs = 10'd1;
        4: fs = SMP_W'($urandom_range(1023, 0));
        default: fs = SMP_W'($urandom_range(1023, 1));
      endcase
      write_full_scale(fs);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // stretch with no idling on either side
        calm = (p == 2) && (n < 150);
        send_sample(pick_sample(fs));
      end
      calm = 1'b0;
    end

    // drain and let the block settle
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_count() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
